// File: hw/rtl/crs_pkg.sv
`default_nettype none

package crs_pkg;

  localparam int CLK_W       = 32;
  localparam int RATE_W      = 20;
  localparam int RATIO_N_W   = 24;
  localparam int RATIO_M_W   = 9;
  localparam int OUT_TDATA_W = 40;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  // Register index is paddr[2] (one 32-bit register per word)
  localparam logic REG_AUDIO_RATE = 1'b0;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

endpackage

`default_nettype wire

// File: hw/rtl/clock_ratio_search_core.sv
`default_nettype none

// Search: with the rate register nonzero, the core tries each denominator from 1 up to
//   MAX_M and stops early on an exact hit; with a zero rate no search runs. Every trial
//   uses the shared restoring divider (DW = 33 + clog2(MAX_M+1) bits, 42 at MAX_M = 256),
//   one quotient bit a cycle.
// Throughput: one item at a time; s_tready is high only while idle, so the next
//   beat is taken at the earliest in the cycle after the result is registered.
// Reset (rst, synchronous): sequencer idle, no result pending, rate register 48000.
module clock_ratio_search_core #(
  parameter int MAX_M  = 256,
  parameter int N_BITS = 24
) (
  input  wire                                clk,
  input  wire                                rst,
  // input stream
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [crs_pkg::CLK_W-1:0]          s_tdata,   // [31:0] src_hz
  // result stream
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [crs_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [23:0] ratio_n, [32:24] ratio_m
  output logic [0:0]                         m_tuser,   // [0] found
  // configuration
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [crs_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire  [crs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [crs_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import crs_pkg::*;

  localparam int MW = $clog2(MAX_M + 1);   // denominator counter width
  localparam int DW = CLK_W + MW + 1;      // clock*M + rate/2
  localparam int PW = RATE_W + MW;         // cross-product width

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_DIV, S_MUL, S_CMP, S_STEP, S_DONE
  } state_t;

  state_t state;

  logic [RATE_W-1:0] rate;
  logic [CLK_W-1:0]  clk_val;
  logic [DW-1:0]     prod;      // clock * m
  logic [MW-1:0]     m;

  logic [RATE_W-1:0] err_c;
  logic [N_BITS-1:0] n_c;
  logic [RATE_W-1:0] best_err;
  logic [N_BITS-1:0] best_n;
  logic [MW-1:0]     best_m;
  logic [PW-1:0]     p_cand;
  logic [PW-1:0]     p_best;

  logic              div_start;
  logic              div_done;
  logic [DW-1:0]     div_quot;
  logic [RATE_W-1:0] div_rem;
  logic [RATE_W-1:0] half;
  logic              n_ok;
  logic [RATE_W-1:0] err_now;
  logic [31:0]       n_ext;
  logic [15:0]       m_ext;

  // Configuration: one register, written on the access phase
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_AUDIO_RATE) ? APB_DATA_W'(rate) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= RATE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_AUDIO_RATE) begin
      rate <= pwdata[RATE_W-1:0];
    end
  end

  assign half      = rate >> 1;
  assign div_start = (state == S_START);

  crs_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod + DW'(half)),
    .divisor  (rate),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // n*rate = prod + half - rem, so the error is |half - rem|
  assign err_now = (half > div_rem) ? (half - div_rem) : (div_rem - half);
  assign n_ok    = (div_quot != '0) && ((div_quot >> N_BITS) == '0);

  assign s_tready = (state == S_IDLE);
  assign n_ext    = 32'(best_n);
  assign m_ext    = 16'(best_m);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      best_m   <= '0;
    end else begin
      // drop a taken beat; S_DONE reloads the register on its own
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            clk_val <= s_tdata;
            prod    <= DW'(s_tdata);
            m       <= MW'(1);
            best_m  <= '0;
            best_n  <= '0;
            best_err <= '0;
            // zero divisor: no search, empty result
            state   <= (rate == '0) ? S_DONE : S_START;
          end
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            err_c <= err_now;
            n_c   <= div_quot[N_BITS-1:0];
            state <= n_ok ? S_MUL : S_STEP;
          end
        end
        S_MUL: begin
          // score err/m against best_err/best_m by cross-multiplying
          p_cand <= PW'(err_c) * PW'(best_m);
          p_best <= PW'(best_err) * PW'(m);
          state  <= S_CMP;
        end
        S_CMP: begin
          if (best_m == '0 || p_cand < p_best) begin
            best_err <= err_c;
            best_n   <= n_c;
            best_m   <= m;
            state    <= (err_c == '0) ? S_DONE : S_STEP;
          end else begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (m == MW'(MAX_M)) begin
            state <= S_DONE;
          end else begin
            m     <= m + 1'b1;
            prod  <= prod + DW'(clk_val);
            state <= S_START;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            m_tuser[0] <= (best_m != '0);
            m_tdata    <= {{(OUT_TDATA_W - RATIO_N_W - RATIO_M_W){1'b0}},
                           m_ext[RATIO_M_W-1:0], n_ext[RATIO_N_W-1:0]};
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/crs_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module crs_div #(
  parameter int DW = 42
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  input  wire  [DW-1:0]               dividend,
  input  wire  [crs_pkg::RATE_W-1:0]  divisor,
  output logic                        done,
  output logic [DW-1:0]               quot,
  output logic [crs_pkg::RATE_W-1:0]  rem
);
  import crs_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0]   cnt;
  logic            busy;
  logic [RATE_W:0] shifted;
  logic            fits;

  assign shifted = {rem, quot[DW-1]};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
        rem  <= '0;
        quot <= dividend;
      end else if (busy) begin
        rem  <= fits ? RATE_W'(shifted - {1'b0, divisor}) : shifted[RATE_W-1:0];
        quot <= {quot[DW-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: bench/clock_ratio_search_core_test.sv
`timescale 1ns / 100ps

module clock_ratio_search_core_test;
  import crs_pkg::*;

  localparam int MAX_M  = 256;
  localparam int N_BITS = 24;
  localparam logic [63:0] N_LIMIT = (64'd1 << N_BITS) - 64'd1;

  // One full search is MAX_M trials, one per denominator. The limit covers every queued
  // item at full-search cost, plus sender gaps and receiver stalls, several times over.
  localparam int unsigned CYCLE_LIMIT = 8_000_000;

  // Register addresses: the register index sits in paddr[2].
  localparam logic [APB_ADDR_W-1:0] ADDR_AUDIO_RATE = {REG_AUDIO_RATE, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED   = {~REG_AUDIO_RATE, 2'b00};

  typedef struct packed {
    logic                 found;
    logic [RATIO_N_W-1:0] n;
    logic [RATIO_M_W-1:0] m;
  } ratio_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [CLK_W-1:0]      s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [0:0]            m_tuser;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Shadow of the sample rate register, updated as each write lands.
  logic [RATE_W-1:0] rate_shadow = RATE_RESET;

  logic [CLK_W-1:0] clock_backlog[$];   // clock rates waiting to be driven
  ratio_t           ratio_expected[$];  // predicted ratios, oldest first

  int unsigned items_queued = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;

  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;

  clock_ratio_search_core #(
    .MAX_M  (MAX_M),
    .N_BITS (N_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Walk every denominator, round the numerator, and keep the strictly best
  // error-per-denominator score; the first exact hit ends the walk.
  function automatic ratio_t search_ratio(input logic [CLK_W-1:0] clock_hz,
                                          input logic [RATE_W-1:0] rate);
    ratio_t      best;
    logic [63:0] prod;
    logic [63:0] num;
    logic [63:0] lhs;
    logic [63:0] err;
    logic [63:0] best_err;
    logic [63:0] best_n;
    logic [63:0] best_m;
    best_err = '0;
    best_n   = '0;
    best_m   = '0;
    if (rate != '0) begin
      for (int unsigned m = 1; m <= MAX_M; m++) begin
        prod = 64'(clock_hz) * 64'(m);
        num  = (prod + 64'(rate) / 64'd2) / 64'(rate);
        if (num == 64'd0 || num > N_LIMIT) continue;
        lhs = num * 64'(rate);
        err = (lhs > prod) ? lhs - prod : prod - lhs;
        // Cross-multiply the scores: err/m < best_err/best_m.
        if (best_m == 64'd0 || err * best_m < best_err * 64'(m)) begin
          best_err = err;
          best_n   = num;
          best_m   = 64'(m);
          if (err == 64'd0) break;
        end
      end
    end
    best.found = (best_m != 64'd0);
    best.n     = best_n[RATIO_N_W-1:0];
    best.m     = best_m[RATIO_M_W-1:0];
    return best;
  endfunction

  // Mix of raw 32-bit values, audio-range clocks, exact multiples of the rate
  // (early exact hits) and small clocks near the not-found edge.
  function automatic logic [CLK_W-1:0] pick_clock(input logic [RATE_W-1:0] rate);
    logic [63:0] wide;
    case ($urandom_range(0, 5))
      0, 1: wide = 64'($urandom);
      2:    wide = 64'($urandom_range(1_000_000, 200_000_000));
      3:    wide = 64'(rate) * 64'($urandom_range(1, 2048));
      4:    wide = 64'(rate) * 64'($urandom_range(1, 4096)) + 64'($urandom_range(0, 7));
      default: wide = 64'($urandom_range(0, 32'(rate) * 4 + 16));
    endcase
    return wide[CLK_W-1:0];
  endfunction

  task automatic queue_clock(input logic [CLK_W-1:0] clock_hz);
    clock_backlog.push_back(clock_hz);
    items_queued++;
  endtask

  // Hold until every queued clock rate has come back as a checked result.
  task automatic drain_results();
    do @(negedge clk); while (results_seen != items_queued);
  endtask

  // Setup beat, then access beat; the register lands on the edge with pready high.
  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[2] == REG_AUDIO_RATE) rate_shadow = data[RATE_W-1:0];
  endtask

  task automatic queue_random(input int unsigned count);
    repeat (count) queue_clock(pick_clock(rate_shadow));
  endtask

  // Sender: bursts of random length separated by random gaps. A quarter of the
  // gaps are zero, which gives back-to-back stretches.
  always @(posedge clk) begin
    logic take;
    take = s_tvalid && s_tready;
    if (take) ratio_expected.push_back(search_ratio(s_tdata, rate_shadow));
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || take) begin
      if (gap_left != 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (clock_backlog.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= clock_backlog.pop_front();
        if (burst_left == 0) begin
          burst_left = $urandom_range(0, 4);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, with a free-running window whenever bit 12 of the cycle
  // count is set, so that some results are taken at once.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (cycle_count[12]) begin
      m_tready <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 12);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    ratio_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (ratio_expected.size() == 0) begin
        $error("result beat with no prediction waiting: tuser %h tdata %h", m_tuser, m_tdata);
        fail_count++;
      end else begin
        want = ratio_expected.pop_front();
        if (m_tuser[0] !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, m_tuser[0]);
          fail_count++;
        end
        if (m_tdata[RATIO_N_W-1:0] !== want.n) begin
          $error("ratio_n: expected %0d, got %0d", want.n, m_tdata[RATIO_N_W-1:0]);
          fail_count++;
        end
        if (m_tdata[RATIO_N_W +: RATIO_M_W] !== want.m) begin
          $error("ratio_m: expected %0d, got %0d", want.m, m_tdata[RATIO_N_W +: RATIO_M_W]);
          fail_count++;
        end
        results_seen++;
      end
    end
  end

  // Watchdog: abort the run if it overruns the budget.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Write to an unmapped address: must leave the reset rate of 48000 alone.
    apb_write(ADDR_UNMAPPED, 32'd12345);

    // Reset rate: zero clock and a clock too slow for any N are not found,
    // half the rate hits exactly at M = 2, the rest are common audio clocks, a 27 MHz clock and large 32-bit clocks.
    queue_clock(32'd0);
    queue_clock(32'd1);
    queue_clock(32'd24000);
    queue_clock(32'd48000);
    queue_clock(32'd12_288_000);
    queue_clock(32'd11_289_600);
    queue_clock(32'd27_000_000);
    queue_clock(32'h8000_0000);
    queue_clock(32'hFFFF_FFFF);
    queue_random(30);
    drain_results();

    // Rate of one; write junk in the upper bits, which the register drops.
    // Every N above 24 bits is skipped, so large clocks are not found.
    apb_write(ADDR_AUDIO_RATE, 32'hFFF0_0001);
    queue_clock(32'd0);
    queue_clock(32'd16_777_215);
    queue_clock(32'd16_777_216);
    queue_clock(32'hFFFF_FFFF);
    queue_random(6);
    drain_results();

    // Rate of zero: no division at all, always not found.
    apb_write(ADDR_AUDIO_RATE, 32'd0);
    queue_clock(32'd0);
    queue_clock(32'd48000);
    queue_clock(32'hFFFF_FFFF);
    queue_random(5);
    drain_results();

    // Largest rate: every register bit high.
    apb_write(ADDR_AUDIO_RATE, 32'h000F_FFFF);
    queue_clock(32'd0);
    queue_clock(32'd524_287);
    queue_clock(32'd1_048_575);
    queue_clock(32'hFFFF_FFFF);
    queue_random(15);
    drain_results();

    apb_write(ADDR_AUDIO_RATE, 32'd44100);
    queue_random(15);
    drain_results();

    // Random rate across the full range, with random upper write bits.
    apb_write(ADDR_AUDIO_RATE, {12'($urandom), 20'($urandom_range(1, 1_048_575))});
    queue_random(15);
    drain_results();

    // Small rate: wide numerators push many trials past the N limit.
    apb_write(ADDR_AUDIO_RATE, 32'($urandom_range(1, 1000)));
    queue_random(10);
    drain_results();

    // Let any stray beat surface before the verdict.
    repeat (200) @(posedge clk);
    if (ratio_expected.size() != 0) begin
      $error("%0d predicted results never arrived", ratio_expected.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/crs_pkg.sv
hw/rtl/crs_div.sv
hw/rtl/clock_ratio_search_core.sv
bench/clock_ratio_search_core_test.sv
